// ===== hdl/u8s8dpa_pkg.sv =====
package u8s8dpa_pkg;

	localparam int BYTE_W      = 8;
	localparam int CHUNK_BYTES = 16;
	localparam int PAIR_COUNT  = 8;
	localparam int LANE_COUNT  = 4;
	localparam int PAIR_W      = 16;
	localparam int PROD_W      = 17;
	localparam int PAIR_SUM_W  = 18;
	localparam int LANE_W      = 32;
	localparam int IN_DATA_W   = 4 * 64;
	localparam int OUT_DATA_W  = 32;

	localparam logic signed [PAIR_W-1:0] PAIR_MAX = 16'sh7fff;
	localparam logic signed [PAIR_W-1:0] PAIR_MIN = 16'sh8000;

	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef pair_t [PAIR_COUNT-1:0] pair_vec_t;
	typedef logic [LANE_W-1:0] lane_t;
	typedef lane_t [LANE_COUNT-1:0] lane_vec_t;

	// Handshake between the pair stage and the lane bank.
	typedef struct packed {
		logic advance;
		logic last;
	} stage_ctrl_t;

endpackage

// ===== hdl/u8s8dpa_pair.sv =====
module u8s8dpa_pair (
	input  logic                              clk,
	input  logic                              load,
	input  logic [u8s8dpa_pkg::BYTE_W-1:0]    ubyte0,
	input  logic [u8s8dpa_pkg::BYTE_W-1:0]    ubyte1,
	input  logic [u8s8dpa_pkg::BYTE_W-1:0]    sbyte0,
	input  logic [u8s8dpa_pkg::BYTE_W-1:0]    sbyte1,
	output u8s8dpa_pkg::pair_t                pair_s1
);
	import u8s8dpa_pkg::*;

	logic signed [PROD_W-1:0]     prod0;
	logic signed [PROD_W-1:0]     prod1;
	logic signed [PAIR_SUM_W-1:0] pair_sum;
	pair_t                        pair_sat;

	assign prod0    = $signed({1'b0, ubyte0}) * $signed(sbyte0);
	assign prod1    = $signed({1'b0, ubyte1}) * $signed(sbyte1);
	assign pair_sum = PAIR_SUM_W'(prod0) + PAIR_SUM_W'(prod1);

	// Clamp to the signed 16-bit range.
	always_comb begin
		if (pair_sum > PAIR_SUM_W'(PAIR_MAX)) begin
			pair_sat = PAIR_MAX;
		end else if (pair_sum < PAIR_SUM_W'(PAIR_MIN)) begin
			pair_sat = PAIR_MIN;
		end else begin
			pair_sat = pair_sum[PAIR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pair_s1 <= pair_sat;
		end
	end

endmodule

// ===== hdl/u8s8dpa_lanes.sv =====
module u8s8dpa_lanes (
	input  logic                     clk,
	input  logic                     arst_n,
	input  u8s8dpa_pkg::stage_ctrl_t ctrl,
	input  u8s8dpa_pkg::pair_vec_t   pairs_s1,
	output u8s8dpa_pkg::lane_vec_t   lanes_s2
);
	import u8s8dpa_pkg::*;

	lane_vec_t acc_q;
	lane_vec_t acc_next;

	always_comb begin
		for (int p = 0; p < LANE_COUNT; p++) begin
			acc_next[p] = acc_q[p] + LANE_W'(pairs_s1[p]) + LANE_W'(pairs_s1[p + LANE_COUNT]);
		end
	end

	// Clear the lanes once a closing chunk has been folded in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.advance) begin
			acc_q <= ctrl.last ? '0 : acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance && ctrl.last) begin
			lanes_s2 <= acc_next;
		end
	end

endmodule

// ===== hdl/u8s8dpa_merge.sv =====
module u8s8dpa_merge (
	input  logic                                 clk,
	input  logic                                 load,
	input  u8s8dpa_pkg::lane_vec_t               lanes_s2,
	output logic [u8s8dpa_pkg::OUT_DATA_W-1:0]   total_q
);
	import u8s8dpa_pkg::*;

	lane_t sum_lo;
	lane_t sum_hi;

	assign sum_lo = lanes_s2[0] + lanes_s2[1];
	assign sum_hi = lanes_s2[2] + lanes_s2[3];

	always_ff @(posedge clk) begin
		if (load) begin
			total_q <= sum_lo + sum_hi;
		end
	end

endmodule

// ===== hdl/u8s8_dot_product_accumulator_unit.sv =====
// u8s8 dot product accumulator: every input transaction carries one 16-byte
// chunk, 16 unsigned bytes against 16 signed bytes. Eight pair units multiply
// neighboring byte pairs and clamp each pair sum to signed 16 bits; four lane
// accumulators add pair p and pair p+4 with 32-bit wrap. A transaction with
// s_tlast set closes the dot product: its chunk is folded in, the four lanes
// are summed (32-bit wrap) into one output transaction, and the lanes restart
// at zero for the next chunk. The unit takes one chunk per clock cycle while
// no closing chunk waits for room in the snapshot stage; the rate is set by
// the lane accumulator loop, one add per chunk. A closing chunk passes the
// pair stage, then the lane snapshot, and the merge adder loads its total
// into the output register, which drives m_tvalid. The result waits in the
// output register while further chunks keep streaming in; up to three
// pending results are held before s_tready drops. Reset clears the lanes.
module u8s8_dot_product_accumulator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [63:0] unsigned_bytes_low, [127:64] unsigned_bytes_high,
	// [191:128] signed_bytes_low, [255:192] signed_bytes_high
	input  logic [u8s8dpa_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                                s_tlast,   // last_chunk
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] dot_product, signed
	output logic [u8s8dpa_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import u8s8dpa_pkg::*;

	localparam int HALF_W = CHUNK_BYTES * BYTE_W;

	logic              valid_s1;
	logic              last_s1;
	logic              valid_s2;
	logic              out_valid_q;
	logic              load_s1;
	logic              adv_s1;
	logic              adv_s2;
	logic [HALF_W-1:0] ubytes;
	logic [HALF_W-1:0] sbytes;
	pair_vec_t         pairs_s1;
	lane_vec_t         lanes_s2;
	stage_ctrl_t       lane_ctrl;

	assign ubytes = s_tdata[HALF_W-1:0];
	assign sbytes = s_tdata[2*HALF_W-1:HALF_W];

	// Stage advance: a non-closing chunk only feeds the lanes and always moves
	// on; a closing chunk needs room in the snapshot stage.
	assign adv_s2   = valid_s2 && (!out_valid_q || m_tready);
	assign adv_s1   = valid_s1 && (!last_s1 || !valid_s2 || adv_s2);
	assign s_tready = !valid_s1 || adv_s1;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1 && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			last_s1 <= s_tlast;
		end
	end

	// One pair unit per byte pair of the chunk.
	for (genvar p = 0; p < PAIR_COUNT; p++) begin : g_pair
		u8s8dpa_pair u_pair (
			.clk     (clk),
			.load    (load_s1),
			.ubyte0  (ubytes[2*p*BYTE_W +: BYTE_W]),
			.ubyte1  (ubytes[(2*p+1)*BYTE_W +: BYTE_W]),
			.sbyte0  (sbytes[2*p*BYTE_W +: BYTE_W]),
			.sbyte1  (sbytes[(2*p+1)*BYTE_W +: BYTE_W]),
			.pair_s1 (pairs_s1[p])
		);
	end

	assign lane_ctrl.advance = adv_s1;
	assign lane_ctrl.last    = last_s1;

	u8s8dpa_lanes u_lanes (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lane_ctrl),
		.pairs_s1 (pairs_s1),
		.lanes_s2 (lanes_s2)
	);

	u8s8dpa_merge u_merge (
		.clk      (clk),
		.load     (adv_s2),
		.lanes_s2 (lanes_s2),
		.total_q  (m_tdata)
	);

	assign m_tvalid = out_valid_q;

endmodule

// ===== hdl/u8s8dpa_checker.sv =====
module u8s8dpa_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                s_tlast,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [u8s8dpa_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import u8s8dpa_pkg::*;

	logic       last_in;
	logic       out_done;
	logic [2:0] pending_q;

	assign last_in  = s_tvalid && s_tready && s_tlast;
	assign out_done = m_tvalid && m_tready;

	// Closing chunks accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !out_done) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_done && !last_in) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 3'd0)
		else $error("result without a closing chunk");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more pending results than pipeline stages");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> s_tready)
		else $error("input stalled with no result pending");

endmodule

bind u8s8_dot_product_accumulator_unit u8s8dpa_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import u8s8dpa_pkg::*;

	localparam int CLK_HIGH     = 5;
	localparam int CLK_LOW      = 5;
	localparam int RESET_CYCLES = 5;
	// Three pipeline stages plus margin before the final verdict.
	localparam int DRAIN_CYCLES = 20;
	// Long frames of saturated chunks build much larger sums than random frames.
	localparam int LONG_FRAME   = 40;
	localparam int RANDOM_ITEMS = 340;
	localparam int RUN_LIMIT_NS = 5_000_000;

	typedef enum int {
		STYLE_UNIFORM,
		STYLE_SATURATE,
		STYLE_SMALL,
		STYLE_CORNER
	} chunk_style_e;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;

	// Lane accumulators as the block should hold them after each accepted chunk.
	lane_vec_t                     lane_acc = '0;
	// Dot products predicted but not yet seen on the output, oldest first.
	logic signed [OUT_DATA_W-1:0]  pending_dots[$];

	int mismatch_count = 0;
	int src_idle_pct   = 0;
	int sink_idle_pct  = 0;

	u8s8_dot_product_accumulator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#CLK_LOW clk = 1'b1;
		#CLK_HIGH clk = 1'b0;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Fold one chunk into the lanes; on a closing chunk, queue the lane total
	// and clear the lanes.
	task automatic fold_chunk(input logic [IN_DATA_W-1:0] chunk, input logic last);
		int    u0, u1, s0, s1, sum;
		pair_t pairs [PAIR_COUNT];
		lane_t total;
		for (int p = 0; p < PAIR_COUNT; p++) begin
			u0 = int'(chunk[16*p +: 8]);
			u1 = int'(chunk[16*p+8 +: 8]);
			s0 = $signed(chunk[128+16*p +: 8]);
			s1 = $signed(chunk[128+16*p+8 +: 8]);
			sum = u0 * s0 + u1 * s1;
			// clamp the pair sum to signed 16 bits
			if (sum > 32767)
				sum = 32767;
			else if (sum < -32768)
				sum = -32768;
			pairs[p] = pair_t'(sum);
		end
		// pair p and pair p+4 land in the same lane, wrapping at 32 bits
		for (int l = 0; l < LANE_COUNT; l++)
			lane_acc[l] = lane_acc[l] + lane_t'(int'(pairs[l]))
				+ lane_t'(int'(pairs[l+LANE_COUNT]));
		if (last) begin
			total = '0;
			for (int l = 0; l < LANE_COUNT; l++)
				total = total + lane_acc[l];
			pending_dots.push_back(total);
			lane_acc = '0;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	// with s_tvalid still high, so back-to-back chunks never drop it.
	task automatic send_chunk(input logic [IN_DATA_W-1:0] chunk, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = chunk;
		s_tlast  = last;
		do
			@(posedge clk);
		while (!s_tready);
		fold_chunk(chunk, last);
		@(negedge clk);
	endtask

	// Hold the sender off until every predicted dot product has come out.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_dots.size() != 0)
			@(negedge clk);
	endtask

	// Build a chunk from one byte pattern per even/odd position.
	function automatic logic [IN_DATA_W-1:0] pattern_chunk(input logic [7:0] u_even,
		input logic [7:0] u_odd, input logic [7:0] s_even, input logic [7:0] s_odd);
		logic [IN_DATA_W-1:0] chunk;
		for (int i = 0; i < CHUNK_BYTES; i++) begin
			chunk[8*i +: 8]     = i[0] ? u_odd : u_even;
			chunk[128+8*i +: 8] = i[0] ? s_odd : s_even;
		end
		return chunk;
	endfunction

	function automatic logic [IN_DATA_W-1:0] random_chunk();
		logic [IN_DATA_W-1:0] chunk;
		chunk_style_e         style;
		logic                 negative;
		logic [7:0]           b;
		style    = chunk_style_e'($urandom_range(STYLE_CORNER));
		negative = 1'($urandom_range(1));
		for (int i = 0; i < 2 * CHUNK_BYTES; i++) begin
			b = 8'($urandom);
			case (style)
				STYLE_SATURATE: begin
					// large unsigned against same-sign extremes pushes pairs past 16 bits
					if (i < CHUNK_BYTES)
						b = 8'($urandom_range(128, 255));
					else
						b = negative ? 8'($urandom_range(8'h80, 8'h8f))
							: 8'($urandom_range(8'h70, 8'h7f));
				end
				STYLE_SMALL: begin
					b = (i < CHUNK_BYTES) ? 8'($urandom_range(7))
						: 8'(int'($urandom_range(7)) - 4);
				end
				STYLE_CORNER: begin
					case ($urandom_range(4))
						0: b = 8'h00;
						1: b = 8'hff;
						2: b = 8'h7f;
						3: b = 8'h80;
						default: ;
					endcase
				end
				default: ;
			endcase
			chunk[8*i +: 8] = b;
		end
		return chunk;
	endfunction

	// Extremes, exact clamp boundaries and a multi-chunk frame.
	task automatic test_directed();
		send_chunk(pattern_chunk(8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
		send_chunk(pattern_chunk(8'hff, 8'hff, 8'h7f, 8'h7f), 1'b1);
		send_chunk(pattern_chunk(8'hff, 8'hff, 8'h80, 8'h80), 1'b1);
		send_chunk(pattern_chunk(8'hff, 8'hff, 8'h7f, 8'h80), 1'b1);
		send_chunk(pattern_chunk(8'hff, 8'hff, 8'hff, 8'hff), 1'b1);
		// pair sum exactly at the positive limit, then two past it
		send_chunk(pattern_chunk(8'hff, 8'hbf, 8'h7f, 8'h02), 1'b1);
		send_chunk(pattern_chunk(8'hff, 8'hc0, 8'h7f, 8'h02), 1'b1);
		// pair sum exactly at the negative limit, then two past it
		send_chunk(pattern_chunk(8'hff, 8'h40, 8'h80, 8'hfe), 1'b1);
		send_chunk(pattern_chunk(8'hff, 8'h41, 8'h80, 8'hfe), 1'b1);
		send_chunk(pattern_chunk(8'h55, 8'haa, 8'h55, 8'haa), 1'b1);
		send_chunk(pattern_chunk(8'haa, 8'h55, 8'haa, 8'h55), 1'b1);
		// chunks without the last mark keep accumulating
		repeat (3)
			send_chunk(pattern_chunk(8'hff, 8'hff, 8'h7f, 8'h7f), 1'b0);
		send_chunk(pattern_chunk(8'h01, 8'h02, 8'h03, 8'hfd), 1'b1);
		for (int k = 0; k < 5; k++)
			send_chunk({$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom}, k == 4);
		wait_drained();
	endtask

	// Random frames of mostly short length, a few long ones; drain halfway.
	task automatic test_random_frames(input int item_target);
		int sent;
		int len;
		bit paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < item_target) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			for (int k = 0; k < len; k++)
				send_chunk(random_chunk(), k == len - 1);
			sent += len;
			if (!paused && sent >= item_target / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		wait_drained();
	endtask

	// Long saturated frames drive the lanes to large sums of both signs.
	task automatic test_lane_wrap();
		for (int n = 0; n < LONG_FRAME; n++)
			send_chunk(pattern_chunk(8'hff, 8'hff, 8'h7f, 8'h7f), n == LONG_FRAME - 1);
		for (int n = 0; n < LONG_FRAME; n++)
			send_chunk(pattern_chunk(8'hff, 8'hff, 8'h80, 8'h80), n == LONG_FRAME - 1);
		wait_drained();
	endtask

	// Receiver: decide ready at the falling edge, check at the rising edge.
	always @(negedge clk)
		m_tready = ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_dots.size() == 0) begin
				report_mismatch($sformatf("dot_product %0d with nothing pending",
					$signed(m_tdata)));
			end else begin
				if (m_tdata !== pending_dots[0])
					report_mismatch($sformatf("dot_product got %0d expected %0d",
						$signed(m_tdata), pending_dots[0]));
				void'(pending_dots.pop_front());
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();

		src_idle_pct  = 25;
		sink_idle_pct = 86;
		test_random_frames(RANDOM_ITEMS);

		src_idle_pct  = 86;
		sink_idle_pct = 25;
		test_random_frames(RANDOM_ITEMS);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random_frames(RANDOM_ITEMS);
		test_lane_wrap();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/u8s8dpa_pkg.sv
hdl/u8s8dpa_pair.sv
hdl/u8s8dpa_lanes.sv
hdl/u8s8dpa_merge.sv
hdl/u8s8_dot_product_accumulator_unit.sv
hdl/u8s8dpa_checker.sv
test/tb.sv
